[design/accel_motion_detector_core_assert.svh]
// Assertion macros for the motion detector core.
`ifndef ACCEL_MOTION_DETECTOR_CORE_ASSERT_SVH
`define ACCEL_MOTION_DETECTOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled in reset.
`define AMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("motion detector assertion failed");
// Next-cycle implication, disabled in reset.
`define AMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("motion detector assertion failed");
`else
`define AMD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define AMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/amd_pkg.sv]
// Shared constants for the accelerometer motion detector.
package amd_pkg;
    localparam int WIN_DEPTH_DEF = 8;
    localparam int FRAC_BITS_DEF = 8;
    localparam int MAG_W         = 25;
    localparam int GZ_RST_LSB    = 16390;

    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_FAIL    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [1:0] CFG_THRESH = 2'd0;
    localparam logic [1:0] CFG_BASE   = 2'd1;
    localparam logic [1:0] CFG_ZERO   = 2'd2;

    localparam logic [MAG_W-1:0] THR_RST  = 25'd209664;
    localparam logic [7:0]       BASE_RST = 8'd50;
    localparam logic [7:0]       ZERO_RST = 8'd5;
    localparam logic [8:0]       LP_DIV   = 9'd50;
endpackage

[design/accel_motion_detector_core.sv]
// Accelerometer motion detector core: gravity tracking, deviation magnitude, windowed mean.
// One transaction in, one status transaction out. Input is taken only in idle; the
// core then runs one shared restoring divider (one bit a cycle) and a bit-pair square
// root. Restart, read-failure, offline and all-zero transactions go straight from
// idle to the output state. A baseline sample runs three gravity divisions; a
// tracking sample runs three gravity divisions, three squares, the root and the
// window-mean division. The result is held on the output until taken; the next
// input is accepted after that.
// Window contents are not cleared on restart; only entries written since restart
// are read.
module accel_motion_detector_core #(
    parameter int WIN_DEPTH = amd_pkg::WIN_DEPTH_DEF,
    parameter int FRAC_BITS = amd_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [24:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // accel_x, accel_y, accel_z
    input  logic [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // motion_level, zero fill
    output logic [2:0]  m_axis_tuser   // moving, baseline_ready, offline
);
    localparam int MW = amd_pkg::MAG_W;
    localparam int PW = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int TW = $clog2(WIN_DEPTH + 1);
    localparam int SW = MW + TW;
    localparam int DW = 34;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DSET = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_GUPD = 4'd3;
    localparam logic [3:0] ST_SQ   = 4'd4;
    localparam logic [3:0] ST_ACC  = 4'd5;
    localparam logic [3:0] ST_SQRT = 4'd6;
    localparam logic [3:0] ST_WIN  = 4'd7;
    localparam logic [3:0] ST_MEAN = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0]           r_state;
    logic [MW-1:0]        r_thr;
    logic [7:0]           r_base;
    logic [7:0]           r_zmax;
    logic signed [31:0]   r_grav [3];
    logic [7:0]           r_bcnt;
    logic                 r_done;
    logic [PW-1:0]        r_pos;
    logic                 r_filled;
    logic [7:0]           r_zrun;
    logic                 r_offline;
    logic [MW-1:0]        r_level;
    logic                 r_moving;
    logic [SW-1:0]        r_sum;

    logic [15:0]          r_ax [3];
    logic [1:0]           r_axis;
    logic [DW-1:0]        r_dvd;
    logic [8:0]           r_rem;
    logic [8:0]           r_dsr;
    logic [5:0]           r_cnt;
    logic                 r_neg;
    logic                 r_mean;
    logic [2*MW-1:0]      r_sq;
    logic [51:0]          r_acc;
    logic [51:0]          r_rad;
    logic [51:0]          r_root;
    logic [51:0]          r_bitv;

    logic                 w_in_acc;
    logic [1:0]           w_req;
    logic                 w_zero;
    logic                 w_work;
    logic [7:0]           w_zrun;
    logic signed [32:0]   w_fa;
    logic signed [32:0]   w_dev;
    logic [32:0]          w_abs;
    logic [MW-1:0]        w_sat;
    logic [8:0]           w_ddiv;
    logic [9:0]           w_t;
    logic [9:0]           w_tsub;
    logic                 w_ge;
    logic [DW-1:0]        w_q;
    logic [51:0]          w_trial;
    logic [MW-1:0]        w_mag;
    logic [MW-1:0]        w_old;
    logic [PW-1:0]        n_pos;
    logic                 n_filled;
    logic [TW-1:0]        w_total;
    logic [SW-1:0]        n_sum;
    logic [7:0]           n_bcnt;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_req    = s_axis_tuser;
    assign w_zero   = (s_axis_tdata == 48'd0);
    assign w_zrun   = (r_zrun != 8'hFF) ? r_zrun + 8'd1 : r_zrun;
    // only an online non-zero sample needs the arithmetic sequence
    assign w_work   = (w_req == amd_pkg::REQ_SAMPLE) && !r_offline && !w_zero;

    assign w_fa  = {{(17 - FRAC_BITS){r_ax[r_axis][15]}}, r_ax[r_axis], {FRAC_BITS{1'b0}}};
    assign w_dev = w_fa - {r_grav[r_axis][31], r_grav[r_axis]};
    assign w_abs = w_dev[32] ? 33'(-w_dev) : 33'(w_dev);
    assign w_sat = (|w_abs[32:MW]) ? {MW{1'b1}} : w_abs[MW-1:0];
    assign w_ddiv = r_done ? amd_pkg::LP_DIV : {1'b0, r_bcnt} + 9'd1;

    // restoring divider step
    assign w_t    = {r_rem, r_dvd[DW-1]};
    assign w_tsub = w_t - {1'b0, r_dsr};
    assign w_ge   = (w_t >= {1'b0, r_dsr});
    assign w_q    = r_neg ? DW'(-r_dvd) : r_dvd;

    assign w_trial = r_root + r_bitv;
    assign w_mag   = (|r_root[51:MW]) ? {MW{1'b1}} : r_root[MW-1:0];

    assign n_pos    = (r_pos == PW'(WIN_DEPTH - 1)) ? '0 : r_pos + PW'(1);
    assign n_filled = r_filled || (n_pos == '0);
    assign w_total  = n_filled ? TW'(WIN_DEPTH) : TW'(n_pos);
    assign n_sum    = r_sum + SW'(w_mag) - (r_filled ? SW'(w_old) : SW'(0));
    assign n_bcnt   = (r_bcnt != 8'hFF) ? r_bcnt + 8'd1 : r_bcnt;

    amd_ram #(.WIDTH(MW), .DEPTH(WIN_DEPTH)) u_win (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_WIN),
        .i_waddr (r_pos),
        .i_wdata (w_mag),
        .i_raddr (r_pos),
        .o_rdata (w_old)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_thr     <= amd_pkg::THR_RST;
            r_base    <= amd_pkg::BASE_RST;
            r_zmax    <= amd_pkg::ZERO_RST;
            r_grav[0] <= '0;
            r_grav[1] <= '0;
            r_grav[2] <= 32'(amd_pkg::GZ_RST_LSB * (1 << FRAC_BITS));
            r_bcnt    <= '0;
            r_done    <= 1'b0;
            r_pos     <= '0;
            r_filled  <= 1'b0;
            r_zrun    <= '0;
            r_offline <= 1'b0;
            r_level   <= '0;
            r_moving  <= 1'b0;
            r_sum     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    amd_pkg::CFG_THRESH: r_thr  <= i_cfg_data;
                    amd_pkg::CFG_BASE:   r_base <= i_cfg_data[7:0];
                    amd_pkg::CFG_ZERO:   r_zmax <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= w_work ? ST_DSET : ST_OUT;
                        if (w_req == amd_pkg::REQ_RESTART) begin
                            r_zrun    <= '0;
                            r_done    <= 1'b0;
                            r_bcnt    <= '0;
                            r_pos     <= '0;
                            r_filled  <= 1'b0;
                            r_sum     <= '0;
                            r_level   <= '0;
                            r_moving  <= 1'b0;
                            r_offline <= 1'b0;
                            r_grav[0] <= '0;
                            r_grav[1] <= '0;
                            r_grav[2] <= 32'(amd_pkg::GZ_RST_LSB * (1 << FRAC_BITS));
                        end else if (!r_offline) begin
                            if (w_req == amd_pkg::REQ_FAIL) begin
                                r_offline <= 1'b1;
                                r_level   <= '0;
                                r_moving  <= 1'b0;
                                r_done    <= 1'b0;
                            end else if (w_req == amd_pkg::REQ_SAMPLE) begin
                                if (w_zero) begin
                                    r_zrun <= w_zrun;
                                    if (w_zrun >= r_zmax) begin
                                        r_offline <= 1'b1;
                                        r_level   <= '0;
                                        r_moving  <= 1'b0;
                                        r_done    <= 1'b0;
                                    end
                                end else begin
                                    r_zrun <= '0;
                                end
                            end
                        end
                    end
                end
                ST_DSET: r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= r_mean ? ST_MEAN : ST_GUPD;
                    end
                end
                ST_GUPD: begin
                    r_grav[r_axis] <= r_grav[r_axis] + signed'(w_q[31:0]);
                    if (r_axis != 2'd2) begin
                        r_state <= ST_DSET;
                    end else if (!r_done) begin
                        r_bcnt  <= n_bcnt;
                        r_done  <= (n_bcnt >= r_base);
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ:  r_state <= ST_ACC;
                ST_ACC: r_state <= (r_axis == 2'd2) ? ST_SQRT : ST_SQ;
                ST_SQRT: begin
                    if (r_bitv[0]) begin
                        r_state <= ST_WIN;
                    end
                end
                ST_WIN: begin
                    r_sum    <= n_sum;
                    r_pos    <= n_pos;
                    r_filled <= n_filled;
                    r_state  <= ST_DIV;
                end
                ST_MEAN: begin
                    r_level  <= r_dvd[MW-1:0];
                    r_moving <= (r_dvd[MW-1:0] >= r_thr);
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath: divider, squarer, root
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ax[0] <= s_axis_tdata[15:0];
                r_ax[1] <= s_axis_tdata[31:16];
                r_ax[2] <= s_axis_tdata[47:32];
                r_axis  <= 2'd0;
                r_mean  <= 1'b0;
            end
            ST_DSET: begin
                r_neg <= w_dev[32];
                r_dvd <= {1'b0, w_abs} + DW'(w_ddiv[8:1]);
                r_dsr <= w_ddiv;
                r_rem <= '0;
                r_cnt <= 6'(DW - 1);
            end
            ST_DIV: begin
                r_rem <= w_ge ? w_tsub[8:0] : w_t[8:0];
                r_dvd <= {r_dvd[DW-2:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
            end
            ST_GUPD: begin
                r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                r_acc  <= '0;
            end
            ST_SQ: r_sq <= w_sat * w_sat;
            ST_ACC: begin
                // hold the running sum; the last axis seeds the root
                r_acc  <= r_acc + 52'(r_sq);
                r_rad  <= r_acc + 52'(r_sq);
                r_root <= '0;
                r_bitv <= 52'd1 << 50;
                r_axis <= r_axis + 2'd1;
            end
            ST_SQRT: begin
                if (r_rad >= w_trial) begin
                    r_rad  <= r_rad - w_trial;
                    r_root <= (r_root >> 1) + r_bitv;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bitv <= r_bitv >> 2;
            end
            ST_WIN: begin
                r_neg  <= 1'b0;
                r_mean <= 1'b1;
                r_dvd  <= DW'(n_sum);
                r_dsr  <= 9'(w_total);
                r_rem  <= '0;
                r_cnt  <= 6'(DW - 1);
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {{(32 - MW){1'b0}}, r_level};
    assign m_axis_tuser  = {r_offline, r_done, r_moving};

`include "accel_motion_detector_core_assert.svh"

    `AMD_ASSERT_IMPLY(a_moving_online, i_clk, i_rst_n, r_moving, !r_offline)
    `AMD_ASSERT_IMPLY(a_level_needs_base, i_clk, i_rst_n, r_level != '0, r_done)
    `AMD_ASSERT_IMPLY(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `AMD_ASSERT_NEXT(a_restart_out, i_clk, i_rst_n,
        w_in_acc && (w_req == amd_pkg::REQ_RESTART), m_axis_tvalid && !r_offline)
endmodule

[design/amd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module amd_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the accelerometer motion detector core.
`timescale 1ns / 1ps

module tb_top;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int WIN         = amd_pkg::WIN_DEPTH_DEF;
    localparam int FRAC        = amd_pkg::FRAC_BITS_DEF;
    localparam int MW          = amd_pkg::MAG_W;
    localparam longint SAT25   = (64'd1 << MW) - 1;
    // request code with no meaning; the core reports its state unchanged
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [MW-1:0] level;
        logic          moving;
        logic          ready;
        logic          offline;
    } t_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [24:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    accel_motion_detector_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Detector state as predicted
    longint        thr_c, base_c, zero_c;
    longint        grav [3];
    int            base_cnt, win_pos, zcount;
    bit            base_done, win_full, is_off, mov;
    logic [MW-1:0] mag_hist [WIN];
    logic [MW-1:0] lvl;

    t_status status_q [$];
    int      fails = 0;
    int      cycles = 0;
    int      burst_left = 0;
    bit      hold_request = 1'b0;
    int      zero_burst = 0;

    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned sat_square(longint d);
        longint unsigned m = (d < 0) ? -d : d;
        if (m > SAT25) m = SAT25;
        return m * m;
    endfunction

    function automatic void clear_tracking();
        zcount = 0; base_done = 0; base_cnt = 0; win_pos = 0; win_full = 0;
        lvl = '0; mov = 0; is_off = 0;
        grav[0] = 0; grav[1] = 0; grav[2] = longint'(amd_pkg::GZ_RST_LSB) << FRAC;
    endfunction

    function automatic void drop_offline();
        is_off = 1; lvl = '0; mov = 0; base_done = 0;
    endfunction

    function automatic void absorb_sample(logic signed [15:0] a [3]);
        longint f [3];
        longint d [3];
        longint dv;
        longint unsigned mag, acc;
        int n;
        if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
            if (zcount < 255) zcount++;
            if (zcount >= zero_c) drop_offline();
            return;
        end
        zcount = 0;
        dv = base_done ? longint'(amd_pkg::LP_DIV) : base_cnt + 1;
        for (int k = 0; k < 3; k++) begin
            f[k] = longint'(a[k]) <<< FRAC;
            grav[k] = longint'(int'(grav[k] + round_div(f[k] - grav[k], dv)));
        end
        if (!base_done) begin
            if (base_cnt < 255) base_cnt++;
            if (base_cnt >= base_c) base_done = 1;
            return;
        end
        for (int k = 0; k < 3; k++) d[k] = f[k] - grav[k];
        mag = int_sqrt(sat_square(d[0]) + sat_square(d[1]) + sat_square(d[2]));
        if (mag > SAT25) mag = SAT25;
        mag_hist[win_pos] = mag[MW-1:0];
        win_pos = (win_pos + 1) % WIN;
        if (win_pos == 0) win_full = 1;
        n = win_full ? WIN : win_pos;
        acc = 0;
        for (int k = 0; k < n; k++) acc += mag_hist[k];
        lvl = MW'(acc / n);
        mov = (longint'(lvl) >= thr_c);
    endfunction

    function automatic t_status predict_status(logic [1:0] req, logic signed [15:0] a [3]);
        t_status s;
        if (req == amd_pkg::REQ_RESTART) begin
            clear_tracking();
        end else if (!is_off) begin
            if (req == amd_pkg::REQ_FAIL) drop_offline();
            else if (req == amd_pkg::REQ_SAMPLE) absorb_sample(a);
        end
        s.level = lvl; s.moving = mov; s.ready = base_done; s.offline = is_off;
        return s;
    endfunction

    // Offer one transaction; pause between bursts
    task automatic send_item(logic [1:0] req, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        logic signed [15:0] a [3];
        int gap;
        a[0] = x; a[1] = y; a[2] = z;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        status_q.push_back(predict_status(req, a));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        wait (status_q.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [24:0] val);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            amd_pkg::CFG_THRESH: thr_c = val;
            amd_pkg::CFG_BASE:   base_c = val[7:0];
            amd_pkg::CFG_ZERO:   zero_c = val[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [24:0] thr, logic [7:0] base, logic [7:0] zr);
        wait_idle();
        write_reg(amd_pkg::CFG_THRESH, thr);
        write_reg(amd_pkg::CFG_BASE, 25'(base));
        write_reg(amd_pkg::CFG_ZERO, 25'(zr));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly plausible motion around gravity, with full-range values and events
    task automatic send_random();
        int r, amp;
        logic signed [15:0] x, y, z;
        r = $urandom_range(0, 99);
        if (is_off && r < 60) begin
            send_item(amd_pkg::REQ_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (zero_burst > 0) begin
            zero_burst--;
            send_item(amd_pkg::REQ_SAMPLE, '0, '0, '0);
        end else if (r < 4) begin
            zero_burst = $urandom_range(0, zero_c + 1);
            send_item(amd_pkg::REQ_SAMPLE, '0, '0, '0);
        end else if (r < 6) begin
            send_item(amd_pkg::REQ_FAIL, 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (r < 9) begin
            send_item(amd_pkg::REQ_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (r < 10) begin
            send_item(REQ_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
        end else if (r < 18) begin
            send_item(amd_pkg::REQ_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            amp = ($urandom_range(0, 2) == 0) ? 4000 : 200;
            x = 16'($urandom_range(0, 2 * amp)) - 16'(amp);
            y = 16'($urandom_range(0, 2 * amp)) - 16'(amp);
            z = 16'(16384 + $urandom_range(0, 2 * amp) - amp);
            send_item(amd_pkg::REQ_SAMPLE, x, y, z);
        end
    endtask

    task automatic test_directed();
        configure(25'd0, 8'd1, 8'd2);
        send_item(amd_pkg::REQ_FAIL, 16'sd1, 16'sd1, 16'sd1);
        send_item(amd_pkg::REQ_SAMPLE, 16'sd5, 16'sd5, 16'sd5);   // ignored while offline
        send_item(amd_pkg::REQ_RESTART, '0, '0, '0);
        send_item(REQ_UNUSED, 16'sd7, 16'sd7, 16'sd7);
        send_item(amd_pkg::REQ_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_item(amd_pkg::REQ_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768);
        send_item(amd_pkg::REQ_SAMPLE, 16'sh7FFF, -16'sd32768, 16'sd1);
        send_item(amd_pkg::REQ_SAMPLE, '0, '0, '0);
        send_item(amd_pkg::REQ_SAMPLE, -16'sd1, '0, '0);          // clears the zero run
        for (int k = 0; k < 8; k++)
            send_item(amd_pkg::REQ_SAMPLE, 16'(k * 1000), 16'(-k * 500), 16'sd16384);
        send_item(amd_pkg::REQ_SAMPLE, '0, '0, '0);
        send_item(amd_pkg::REQ_SAMPLE, '0, '0, '0);
        send_item(amd_pkg::REQ_FAIL, '0, '0, '0);
        send_item(amd_pkg::REQ_RESTART, '0, '0, '0);
        send_item(amd_pkg::REQ_SAMPLE, 16'sd100, 16'sd200, 16'sd300);
        send_item(amd_pkg::REQ_FAIL, '0, '0, '0);
        configure(25'h1FFFFFF, 8'd255, 8'd1);
        send_item(amd_pkg::REQ_RESTART, '0, '0, '0);
        send_item(amd_pkg::REQ_SAMPLE, '0, '0, '0);
    endtask

    task automatic test_random();
        logic [24:0] thr_set [6] = '{25'h1FFFFFF, 25'd0, 25'd209664, 25'd40000, 25'd400000,
                                    25'd1500000};
        logic [7:0]  base_set [6] = '{8'd255, 8'd1, 8'd50, 8'd3, 8'd8, 8'd1};
        logic [7:0]  zero_set [6] = '{8'd255, 8'd1, 8'd5, 8'd3, 8'd2, 8'd20};
        for (int p = 0; p < 6; p++) begin
            configure(thr_set[p], base_set[p], zero_set[p]);
            zero_burst = 0;
            send_item(amd_pkg::REQ_RESTART, '0, '0, '0);
            repeat ((p == 0) ? 300 : 40) send_random();
        end
        configure(25'($urandom_range(0, 1000000)), 8'($urandom_range(1, 10)), 8'd4);
        send_item(amd_pkg::REQ_RESTART, '0, '0, '0);
        repeat (30) send_random();
    endtask

    // Stall the output long enough that the input backs up
    task automatic test_backpressure();
        wait_idle();
        hold_request = 1'b1;
        send_item(amd_pkg::REQ_RESTART, '0, '0, '0);
        repeat (20) send_random();
    endtask

    // Output side: phases of full rate, random stalls and heavy stalls
    int stall_mode = 0, mode_left = 0, hold_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = 600;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 400);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (status_q.size() == 0) begin
                $error("unexpected status transaction");
                fails++;
            end else begin
                want = status_q.pop_front();
                if (m_axis_tdata[MW-1:0] !== want.level) begin
                    $error("motion_level exp %0d got %0d", want.level,
                           m_axis_tdata[MW-1:0]);
                    fails++;
                end
                if (m_axis_tuser[0] !== want.moving) begin
                    $error("moving exp %0d got %0d", want.moving, m_axis_tuser[0]);
                    fails++;
                end
                if (m_axis_tuser[1] !== want.ready) begin
                    $error("baseline_ready exp %0d got %0d", want.ready, m_axis_tuser[1]);
                    fails++;
                end
                if (m_axis_tuser[2] !== want.offline) begin
                    $error("offline exp %0d got %0d", want.offline, m_axis_tuser[2]);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        thr_c = amd_pkg::THR_RST; base_c = amd_pkg::BASE_RST; zero_c = amd_pkg::ZERO_RST;
        for (int k = 0; k < WIN; k++) mag_hist[k] = '0;
        clear_tracking();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        wait_idle();
        repeat (200) @(posedge i_clk);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[sim.f]
+incdir+design
design/amd_pkg.sv
design/amd_ram.sv
design/accel_motion_detector_core.sv
tb/sv/tb_top.sv
